// File: hdl/msgdf_pkg.sv
// Shared types, codes and helper functions for the message deframe checksum checker.
`default_nettype none

package msgdf_pkg;

  // Result status codes; the first failing check wins, in this order.
  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_FEW_PARTS   = 3'd1,
    STATUS_BAD_HEX     = 3'd2,
    STATUS_MISMATCH    = 3'd3,
    STATUS_BAD_CHANNEL = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SEPARATOR   = 1'b0,
    REG_COMPARE_LOW = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] SEPARATOR_RESET = 8'd58;
  localparam int unsigned CHANNEL_W = 16;
  localparam int unsigned SUM_W     = 32;

  // One result request as it travels through the output buffer.
  typedef struct packed {
    status_t              status;
    logic [CHANNEL_W-1:0] channel_number;
    logic [SUM_W-1:0]     received_sum;
    logic [SUM_W-1:0]     computed_sum;
  } result_t;

  // Decoded hex digit: valid flag and nibble value.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.value = 4'(b - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_decimal(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

// File: hdl/msgdf_out_buf.sv
// Two-entry output buffer (output register plus skid register) for result requests.
`default_nettype none

module msgdf_out_buf
  import msgdf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  // The producer holds off whenever the skid entry is occupied.
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/message_deframe_checksum_check.sv
// Top level of the message deframer and checksum checker.
`default_nettype none

// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+------------------------------------------
// input      | in        | in_valid/in_stall  | data_byte, frame_last
// result     | out       | out_valid/out_stall| status, channel_number, received_sum,
//            |           |                    | computed_sum
// config     | in        | cfg_we             | cfg_index, cfg_data
//
// One byte request is accepted every cycle while in_stall is low; its parse state updates at
// that edge, and on the last byte of a message the result is registered into the output buffer.
// The two-entry output buffer sets the rate: the input stalls only while both its
// output register and its skid register hold results that are not yet taken.
// Reset (rst, synchronous) clears the parse state, empties the output buffer and
// restores the separator to ':' and full 32-bit compare.

module message_deframe_checksum_check
  import msgdf_pkg::*;
#(
  parameter int unsigned MAX_HEX_DIGITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Byte input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 frame_last,
  // Result output channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                status,
  output logic [CHANNEL_W-1:0]      channel_number,
  output logic [SUM_W-1:0]          received_sum,
  output logic [SUM_W-1:0]          computed_sum,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // The digit count saturates one above the maximum to flag an overlong field.
  localparam int unsigned COUNT_W = $clog2(MAX_HEX_DIGITS + 2);
  localparam int unsigned HEX_W   = 4 * MAX_HEX_DIGITS;

  // Configuration registers.
  logic [7:0] separator_byte;
  logic       compare_low16;

  // Parse state.
  logic [SUM_W-1:0]     running_total;
  logic [SUM_W-1:0]     total_at_separator;
  logic [1:0]           separators_seen;
  logic [HEX_W-1:0]     hex_accumulator;
  logic [COUNT_W-1:0]   hex_digit_count;
  logic                 hex_field_bad;
  logic [CHANNEL_W-1:0] channel_accumulator;
  logic                 channel_digit_seen;
  logic                 channel_field_bad;

  logic [SUM_W-1:0]     running_total_next;
  logic [SUM_W-1:0]     total_at_separator_next;
  logic [1:0]           separators_seen_next;
  logic [HEX_W-1:0]     hex_accumulator_next;
  logic [COUNT_W-1:0]   hex_digit_count_next;
  logic                 hex_field_bad_next;
  logic [CHANNEL_W-1:0] channel_accumulator_next;
  logic                 channel_digit_seen_next;
  logic                 channel_field_bad_next;

  logic                 accept;
  logic                 is_separator;
  hex_digit_t           hex_digit;
  logic [CHANNEL_W+3:0] channel_product;
  logic [SUM_W-1:0]     compare_value;
  result_t              result_next;
  result_t              result_out;
  logic                 buf_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_byte <= SEPARATOR_RESET;
      compare_low16  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEPARATOR:   separator_byte <= cfg_data;
        REG_COMPARE_LOW: compare_low16  <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  assign is_separator = (data_byte == separator_byte);
  assign hex_digit    = hex_decode(data_byte);

  // Channel times ten plus the new digit, wide enough to show overflow.
  assign channel_product = ({4'd0, channel_accumulator} << 3)
                         + ({4'd0, channel_accumulator} << 1)
                         + (CHANNEL_W + 4)'(data_byte[3:0]);

  // Per-byte update of the parse state.
  always_comb begin
    running_total_next       = running_total + SUM_W'(data_byte);
    total_at_separator_next  = total_at_separator;
    separators_seen_next     = separators_seen;
    hex_accumulator_next     = hex_accumulator;
    hex_digit_count_next     = hex_digit_count;
    hex_field_bad_next       = hex_field_bad;
    channel_accumulator_next = channel_accumulator;
    channel_digit_seen_next  = channel_digit_seen;
    channel_field_bad_next   = channel_field_bad;

    if (is_separator) begin
      // A separator always wins over any digit interpretation of the byte.
      total_at_separator_next = running_total;
      if (separators_seen != 2'd2) begin
        separators_seen_next = separators_seen + 2'd1;
      end
      hex_accumulator_next = '0;
      hex_digit_count_next = '0;
      hex_field_bad_next   = 1'b0;
    end else if (separators_seen == 2'd0) begin
      if (is_decimal(data_byte)) begin
        channel_digit_seen_next = 1'b1;
        if (!channel_field_bad) begin
          if (channel_product[CHANNEL_W+3:CHANNEL_W] != 4'd0) begin
            channel_field_bad_next = 1'b1;
          end else begin
            channel_accumulator_next = channel_product[CHANNEL_W-1:0];
          end
        end
      end else begin
        channel_field_bad_next = 1'b1;
      end
    end else begin
      if (!hex_digit.valid) begin
        hex_field_bad_next = 1'b1;
      end else if (hex_digit_count < COUNT_W'(MAX_HEX_DIGITS)) begin
        hex_accumulator_next = {hex_accumulator[HEX_W-5:0], hex_digit.value};
        hex_digit_count_next = hex_digit_count + COUNT_W'(1);
      end else begin
        hex_digit_count_next = COUNT_W'(MAX_HEX_DIGITS + 1);
        hex_field_bad_next   = 1'b1;
      end
    end
  end

  // Status checks run on the state as it stands after this byte.
  always_comb begin
    compare_value = compare_low16 ? {16'd0, total_at_separator_next[15:0]}
                                  : total_at_separator_next;
    result_next.channel_number = channel_accumulator_next;
    result_next.received_sum   = SUM_W'(hex_accumulator_next);
    result_next.computed_sum   = total_at_separator_next;
    if (separators_seen_next != 2'd2) begin
      result_next.status = STATUS_FEW_PARTS;
    end else if (hex_digit_count_next == '0 || hex_field_bad_next) begin
      result_next.status = STATUS_BAD_HEX;
    end else if (compare_value != SUM_W'(hex_accumulator_next)) begin
      result_next.status = STATUS_MISMATCH;
    end else if (!channel_digit_seen_next || channel_field_bad_next) begin
      result_next.status = STATUS_BAD_CHANNEL;
    end else begin
      result_next.status = STATUS_OK;
    end
  end

  // Parse state registers; the last byte of a message returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_last)) begin
      running_total       <= '0;
      total_at_separator  <= '0;
      separators_seen     <= '0;
      hex_accumulator     <= '0;
      hex_digit_count     <= '0;
      hex_field_bad       <= 1'b0;
      channel_accumulator <= '0;
      channel_digit_seen  <= 1'b0;
      channel_field_bad   <= 1'b0;
    end else if (accept) begin
      running_total       <= running_total_next;
      total_at_separator  <= total_at_separator_next;
      separators_seen     <= separators_seen_next;
      hex_accumulator     <= hex_accumulator_next;
      hex_digit_count     <= hex_digit_count_next;
      hex_field_bad       <= hex_field_bad_next;
      channel_accumulator <= channel_accumulator_next;
      channel_digit_seen  <= channel_digit_seen_next;
      channel_field_bad   <= channel_field_bad_next;
    end
  end

  msgdf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && frame_last),
    .push_data (result_next),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (result_out)
  );

  assign status         = result_out.status;
  assign channel_number = result_out.channel_number;
  assign received_sum   = result_out.received_sum;
  assign computed_sum   = result_out.computed_sum;

endmodule

`default_nettype wire

// File: tb/sv/message_deframe_checksum_check_test.sv
// Self-checking testbench for the message deframer and checksum checker.
`timescale 1ns / 100ps

module message_deframe_checksum_check_test;
  import msgdf_pkg::*;

  localparam int unsigned HEX_DIGIT_LIMIT = 8;
  // A phase carries about this many byte requests; eight phases give the run its size.
  localparam int unsigned PHASE_BYTES = 190;
  localparam int unsigned PHASE_COUNT = 8;
  // The result is registered into a two-entry output buffer, so these quiet cycles
  // are enough to be sure nothing else is on its way.
  localparam int unsigned SETTLE_CYCLES = 8;
  // About 1550 byte requests; even with idles, stalls and the drains between phases,
  // a correct run stays far below this.
  localparam int unsigned CYCLE_LIMIT = 100000;

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;

  // Ways in which a generated message departs from a clean one.
  typedef enum int {
    FLAW_NONE       = 0,
    FLAW_SUM        = 1,
    FLAW_CHAN_OVER  = 2,
    FLAW_CHAN_ALPHA = 3,
    FLAW_CHAN_EMPTY = 4,
    FLAW_HEX_CHAR   = 5,
    FLAW_HEX_LONG   = 6,
    FLAW_HEX_EMPTY  = 7,
    FLAW_EXTRA_SEP  = 8,
    FLAW_NO_SUM_SEP = 9
  } flaw_kind_t;

  // One byte request waiting for the driver.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'h00;
  logic                 frame_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [CHANNEL_W-1:0] channel_number;
  logic [SUM_W-1:0]     received_sum;
  logic [SUM_W-1:0]     computed_sum;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = REG_SEPARATOR;
  logic [7:0]           cfg_data = 8'h00;

  message_deframe_checksum_check #(
    .MAX_HEX_DIGITS(HEX_DIGIT_LIMIT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .frame_last    (frame_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .channel_number(channel_number),
    .received_sum  (received_sum),
    .computed_sum  (computed_sum),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Stimulus side: the pending byte requests, the message being built, and the
  // register values that the generator has to respect.
  byte_req_t   pending_bytes[$];
  logic [7:0]  frame_buf[$];
  logic [7:0]  gen_sep = SEPARATOR_RESET;
  logic        gen_low16 = 1'b0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned in_idle_pct = 6;
  int unsigned out_stall_pct = 6;
  logic        byte_taken = 1'b0;

  // Checking side: verdicts predicted for messages whose last byte was accepted.
  result_t     pending_verdicts[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;
  int unsigned status_tally[5] = '{default: 0};

  // Our own copy of the parser state and of the two registers.
  logic [31:0] seen_total;
  logic [31:0] sep_snapshot;
  logic [1:0]  sep_count;
  logic [31:0] hex_acc;
  logic [3:0]  hex_count;
  logic        hex_bad;
  logic [15:0] chan_acc;
  logic        chan_seen;
  logic        chan_bad;
  logic [7:0]  model_sep;
  logic        model_low16;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_parse();
    seen_total   = '0;
    sep_snapshot = '0;
    sep_count    = '0;
    hex_acc      = '0;
    hex_count    = '0;
    hex_bad      = 1'b0;
    chan_acc     = '0;
    chan_seen    = 1'b0;
    chan_bad     = 1'b0;
  endfunction

  // Hex digit value of a byte; the return flag is low for anything that is not 0-9,
  // a-f or A-F.
  function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] nib);
    nib = 4'd0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      nib = 4'(b - CHAR_0);
      return 1'b1;
    end
    if (b >= CHAR_LA && b <= CHAR_LF) begin
      nib = 4'(b - CHAR_LA + 8'd10);
      return 1'b1;
    end
    if (b >= CHAR_UA && b <= CHAR_UF) begin
      nib = 4'(b - CHAR_UA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the parser by one accepted byte. On the last byte of a message it
  // fills in the verdict, returns 1 and starts the next message from scratch.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t verdict);
    logic [3:0]  nib;
    logic [31:0] next_chan;
    logic [31:0] cmp_sum;
    verdict = '0;
    if (b == model_sep) begin
      // A separator byte always splits fields, even when it looks like a digit.
      sep_snapshot = seen_total;
      if (sep_count < 2'd2) sep_count = sep_count + 2'd1;
      hex_acc   = '0;
      hex_count = '0;
      hex_bad   = 1'b0;
    end else if (sep_count == 2'd0) begin
      if (b >= CHAR_0 && b <= CHAR_9) begin
        next_chan = 32'(chan_acc) * 32'd10 + 32'(b - CHAR_0);
        chan_seen = 1'b1;
        // Once the channel overflows the accumulator keeps its last good value.
        if (!chan_bad) begin
          if (next_chan > 32'h0000_FFFF) chan_bad = 1'b1;
          else chan_acc = next_chan[15:0];
        end
      end else begin
        chan_bad = 1'b1;
      end
    end else if (!hex_nibble(b, nib)) begin
      hex_bad = 1'b1;
    end else if (hex_count < 4'(HEX_DIGIT_LIMIT)) begin
      hex_acc   = {hex_acc[27:0], nib};
      hex_count = hex_count + 4'd1;
    end else begin
      hex_count = 4'(HEX_DIGIT_LIMIT + 1);
      hex_bad   = 1'b1;
    end
    seen_total = seen_total + 32'(b);
    if (!last) return 1'b0;

    cmp_sum = model_low16 ? {16'h0000, sep_snapshot[15:0]} : sep_snapshot;
    if (sep_count < 2'd2) verdict.status = STATUS_FEW_PARTS;
    else if (hex_count == 4'd0 || hex_bad) verdict.status = STATUS_BAD_HEX;
    else if (cmp_sum != hex_acc) verdict.status = STATUS_MISMATCH;
    else if (!chan_seen || chan_bad) verdict.status = STATUS_BAD_CHANNEL;
    else verdict.status = STATUS_OK;
    verdict.channel_number = chan_acc;
    verdict.received_sum   = hex_acc;
    verdict.computed_sum   = sep_snapshot;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Message building. Bytes collect in frame_buf and go out as one message, with
  // the last flag on the final byte.
  // ---------------------------------------------------------------------------

  function automatic void send_frame();
    byte_req_t req;
    foreach (frame_buf[i]) begin
      req.data = frame_buf[i];
      req.last = (i == frame_buf.size() - 1);
      pending_bytes.push_back(req);
      bytes_queued++;
    end
    frame_buf.delete();
  endfunction

  function automatic logic [31:0] frame_total();
    logic [31:0] acc;
    acc = '0;
    foreach (frame_buf[i]) acc = acc + 32'(frame_buf[i]);
    return acc;
  endfunction

  function automatic void put_decimal(input int unsigned value);
    string digits;
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) frame_buf.push_back(digits[i]);
  endfunction

  // Writes ndig hex digits, most significant first, with leading zeros as needed
  // and the letter case picked at random per digit.
  function automatic void put_hex(input logic [31:0] value, input int unsigned ndig);
    logic [3:0] nib;
    for (int i = int'(ndig) - 1; i >= 0; i--) begin
      nib = 4'(64'(value) >> (4 * i));
      if (nib < 4'd10) frame_buf.push_back(CHAR_0 + 8'(nib));
      else if ($urandom_range(1) == 0) frame_buf.push_back(CHAR_UA + 8'(nib) - 8'd10);
      else frame_buf.push_back(CHAR_LA + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic int unsigned hex_width(input logic [31:0] value);
    int unsigned n;
    n = 1;
    while (n < 8 && (value >> (4 * n)) != 0) n++;
    return n;
  endfunction

  // A byte that is neither the separator nor any of the excluded kinds.
  function automatic logic [7:0] odd_byte(input bit no_digit, input bit no_hex);
    logic [7:0] b;
    logic [3:0] nib;
    do begin
      b = 8'($urandom_range(255));
    end while (b == gen_sep || (no_digit && b >= CHAR_0 && b <= CHAR_9) ||
               (no_hex && hex_nibble(b, nib)));
    return b;
  endfunction

  // Puts the separator and a checksum that matches everything before it.
  function automatic void close_with_sum(input int unsigned ndig);
    logic [31:0] good;
    good = frame_total();
    if (gen_low16) good = good & 32'h0000_FFFF;
    frame_buf.push_back(gen_sep);
    put_hex(good, ndig);
  endfunction

  // channel, separator, payload, separator, checksum, with at most one flaw.
  function automatic void build_message(input flaw_kind_t flaw);
    int unsigned pick;
    int unsigned plen;
    int unsigned need;
    logic [31:0] good;
    pick = $urandom_range(9);
    case (flaw)
      FLAW_CHAN_EMPTY: ;
      FLAW_CHAN_OVER: begin
        if (pick == 0) put_decimal(65536);
        else put_decimal(65536 + $urandom_range(2000000));
      end
      FLAW_CHAN_ALPHA: begin
        if (pick < 6) put_decimal($urandom_range(999));
        frame_buf.push_back(odd_byte(1'b1, 1'b0));
        if (pick > 3) put_decimal($urandom_range(99));
      end
      default: begin
        if (pick == 0) put_decimal(65535);
        else if (pick == 1) put_decimal(0);
        else if (pick < 6) put_decimal($urandom_range(99));
        else put_decimal($urandom_range(65535));
      end
    endcase
    frame_buf.push_back(gen_sep);
    plen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
    repeat (plen) frame_buf.push_back(odd_byte(1'b0, 1'b0));
    if (flaw == FLAW_EXTRA_SEP) begin
      frame_buf.push_back(gen_sep);
      repeat ($urandom_range(4)) frame_buf.push_back(odd_byte(1'b0, 1'b0));
    end

    good = frame_total();
    if (gen_low16) good = good & 32'h0000_FFFF;
    need = hex_width(good);
    // Without the checksum separator the digits just run on inside the payload.
    if (flaw != FLAW_NO_SUM_SEP) frame_buf.push_back(gen_sep);
    case (flaw)
      FLAW_HEX_EMPTY: ;
      FLAW_SUM: begin
        if ($urandom_range(1) == 0) put_hex(good ^ (32'h1 << $urandom_range(31)), 8);
        else put_hex($urandom(), 8);
      end
      FLAW_HEX_LONG: put_hex(good, HEX_DIGIT_LIMIT + 1 + $urandom_range(2));
      FLAW_HEX_CHAR: begin
        if ($urandom_range(1) == 0) begin
          frame_buf.push_back(odd_byte(1'b0, 1'b1));
          put_hex(good, need);
        end else begin
          put_hex(good, need);
          frame_buf.push_back(odd_byte(1'b0, 1'b1));
        end
      end
      default: put_hex(good, need + $urandom_range(HEX_DIGIT_LIMIT - need));
    endcase
  endfunction

  // Short runs of digits, letters, separators and arbitrary bytes.
  function automatic void noise_frame();
    int unsigned pick;
    repeat (1 + $urandom_range(9)) begin
      pick = $urandom_range(99);
      if (pick < 20) frame_buf.push_back(gen_sep);
      else if (pick < 40) frame_buf.push_back(CHAR_0 + 8'($urandom_range(9)));
      else if (pick < 60) frame_buf.push_back(CHAR_UA + 8'($urandom_range(6)));
      else frame_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void random_frame();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 9) noise_frame();
    else if (pick < 55) build_message(FLAW_NONE);
    else build_message(flaw_kind_t'(1 + (pick - 55) % 9));
    send_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Requests change on the falling edge. A request that is still waiting
  // holds its payload; a new one is offered only after the last was taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : byte_driver
    byte_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        req = pending_bytes.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= req.data;
        frame_last <= req.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge: register writes update our
  // copy of the configuration, accepted byte requests run the parser, and accepted
  // results are checked against the oldest predicted verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t verdict;
    result_t want;
    if (rst) begin
      clear_parse();
      model_sep   = SEPARATOR_RESET;
      model_low16 = 1'b0;
      byte_taken <= 1'b0;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d verdicts outstanding", $time,
               pending_verdicts.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      cycle_count++;
      byte_taken <= in_valid && !in_stall;
      if (cfg_we) begin
        if (cfg_index == REG_SEPARATOR) model_sep = cfg_data;
        else if (cfg_index == REG_COMPARE_LOW) model_low16 = cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        bytes_accepted++;
        if (parse_byte(data_byte, frame_last, verdict)) pending_verdicts.push_back(verdict);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status <= 3'd4) status_tally[status]++;
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d chan %0d rx 0x%0h sum 0x%0h",
                   $time, status, channel_number, received_sum, computed_sum);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("channel_number", 32'(want.channel_number), 32'(channel_number));
          compare_field("received_sum", want.received_sum, received_sum);
          compare_field("computed_sum", want.computed_sum, computed_sum);
        end
      end
    end
  end

  // Waits, on falling edges where the counters are stable, until every queued byte
  // has been taken and every predicted verdict has come out, then lets the block
  // settle so that registers can be written safely.
  task automatic drain();
    while (bytes_accepted != bytes_queued || pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Register settings per phase: the reset value again, both compare modes, the
  // separator at both ends of its range, a separator that is a decimal digit and
  // one that is a hex letter.
  logic [7:0] phase_sep[PHASE_COUNT]   = '{8'h3A, 8'h3A, 8'h00, 8'hFF, 8'h2C, 8'h35, 8'h61, 8'h7C};
  logic       phase_low16[PHASE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    int unsigned phase_start;
    bit          paused;
    paused = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed messages under the reset settings (':' and full compare).
    // A lone separator: too few parts.
    frame_buf.push_back(gen_sep);
    send_frame();
    // Two separators and nothing after them: empty checksum field.
    frame_buf.push_back(gen_sep);
    frame_buf.push_back(gen_sep);
    send_frame();
    // A checksum of zero against a sum of one separator: mismatch.
    frame_buf.push_back(gen_sep);
    frame_buf.push_back(gen_sep);
    frame_buf.push_back(CHAR_0);
    send_frame();
    // Matching checksum but no channel digits: bad channel.
    frame_buf.push_back(gen_sep);
    close_with_sum(2);
    send_frame();
    // Shortest clean message, channel zero and empty payload.
    put_decimal(0);
    frame_buf.push_back(gen_sep);
    close_with_sum(2);
    send_frame();
    // Payload with the smallest and largest byte values.
    put_decimal(1);
    frame_buf.push_back(gen_sep);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    close_with_sum(3);
    send_frame();
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_reg(REG_SEPARATOR, phase_sep[p]);
      write_reg(REG_COMPARE_LOW, 8'(phase_low16[p]));
      gen_sep   = phase_sep[p];
      gen_low16 = phase_low16[p];
      settings_used++;
      // One phase runs with neither side ever idling.
      in_idle_pct   = (p == 3) ? 0 : 6;
      out_stall_pct = (p == 3) ? 0 : 6;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        random_frame();
        // Halfway through the second phase the sender stops until the pipeline
        // is completely empty, then carries on.
        if (p == 1 && !paused && bytes_queued - phase_start >= PHASE_BYTES / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      fail_count++;
    end
    $display("Ran %0d byte requests under %0d register settings; %0d results checked.",
             bytes_accepted, settings_used, results_seen);
    $display("Statuses seen: ok %0d, few parts %0d, bad hex %0d, mismatch %0d, bad channel %0d.",
             status_tally[STATUS_OK], status_tally[STATUS_FEW_PARTS],
             status_tally[STATUS_BAD_HEX], status_tally[STATUS_MISMATCH],
             status_tally[STATUS_BAD_CHANNEL]);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/msgdf_pkg.sv
hdl/msgdf_out_buf.sv
hdl/message_deframe_checksum_check.sv
tb/sv/message_deframe_checksum_check_test.sv
